[sv/art_pkg.sv]
// ----------------------------------------------------------------------------
// Anchor range table package
// Shared types, command and status codes, and sizing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

	// Default table depth.
	localparam int ART_MAX_ANCHORS = 16;

	// Width of the three-term range sum.
	localparam int SUM_W = 18;

	// Division by three as a multiply by (2**19 + 1) / 3 and a shift right by 19.
	// The result is exact for every sum below 2**19, which covers SUM_W bits.
	localparam int RECIP_W = 18;
	localparam logic [RECIP_W-1:0] DIV3_RECIP = 18'd174763;
	localparam int DIV3_SHIFT = 19;
	localparam int PROD_W = SUM_W + RECIP_W;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// One command item.
	typedef struct packed {
		cmd_t               command;
		logic [15:0]        anchor_address;
		logic [15:0]        measured_range;
		logic signed [15:0] measured_power;
	} req_t;

	// One result item.
	typedef struct packed {
		status_t            status;
		logic [15:0]        filtered_range;
		logic signed [15:0] signal_power;
		logic [4:0]         entry_count;
	} rsp_t;

	// One stored table entry.
	typedef struct packed {
		logic [15:0]        address;
		logic [15:0]        latest;
		logic [15:0]        previous;
		logic signed [15:0] power;
	} entry_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_LOOK,
		SQ_SHIFT,
		SQ_DIV
	} art_state_t;

endpackage

`default_nettype wire

[sv/art_div3.sv]
// ----------------------------------------------------------------------------
// Divide by three
// Divides the range sum by three with a reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module art_div3
	import art_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] dividend,
	output logic                  done,
	output logic [15:0]           quotient
);

	logic              done_q;
	logic [15:0]       quot_q;
	logic [PROD_W-1:0] product;

	// Multiply by the scaled reciprocal of three; the shift drops the fraction.
	always_comb begin
		product = PROD_W'(dividend) * PROD_W'(DIV3_RECIP);
	end

	// Completion pulse in the cycle after start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// Quotient register.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= 16'(product >> DIV3_SHIFT);
		end
	end

	assign done = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

[sv/anchor_range_table_core.sv]
// ----------------------------------------------------------------------------
// Anchor range table core
// Ordered table of ranging anchors with add, delete, update and query items.
// ----------------------------------------------------------------------------
// An add, and any item naming address zero or an empty table, finishes without
// leaving the idle state. A lookup scans one entry per cycle through the
// registered memory read port; a delete moves later entries down one per cycle,
// and an update then waits in SQ_DIV for the multiply by a third.
// Throughput: one item at a time; busy falls as the result is strobed.
// Reset clears the entry count and sequencer; the result cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module anchor_range_table_core
	import art_pkg::*;
#(
	parameter int MAX_ANCHORS = ART_MAX_ANCHORS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t request,
	output logic      busy,
	output logic      done,
	output rsp_t      response
);

	localparam int CNT_W = $clog2(MAX_ANCHORS + 1);
	localparam int IDX_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

	art_state_t state_q, state_d;
	req_t       req_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic       done_q;
	rsp_t       rsp_q;

	// Table memory.
	entry_t mem [MAX_ANCHORS];
	entry_t rd_q;
	logic   mem_we, mem_re;
	logic [IDX_W-1:0] mem_wa, mem_ra;
	entry_t mem_wd;

	// Divider hookup.
	logic             div_start;
	logic [SUM_W-1:0] div_sum;
	logic             div_done;
	logic [15:0]      div_quot;

	// Finish signals.
	logic fin;
	rsp_t fin_rsp;

	logic [CNT_W:0] idx_p1, idx_p2, count_x;
	logic           hit, last;

	art_div3 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_sum),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Index arithmetic, one bit wider than the count so nothing wraps.
	always_comb begin
		idx_p1 = (CNT_W + 1)'(idx_q) + 1'b1;
		idx_p2 = (CNT_W + 1)'(idx_q) + 2'd2;
		count_x = (CNT_W + 1)'(count_q);
		hit = (rd_q.address == req_q.anchor_address);
		last = (idx_p1 == count_x);
		div_sum = SUM_W'(req_q.measured_range) + SUM_W'(rd_q.latest)
			+ SUM_W'(rd_q.previous);
	end

	// Sequencer: next state, memory control and result selection.
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		count_d = count_q;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = '0;
		div_start = 1'b0;
		fin = 1'b0;
		fin_rsp = '0;
		fin_rsp.status = ST_DONE;
		fin_rsp.entry_count = 5'(count_q);

		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					idx_d = '0;
					if (request.command == CMD_ADD) begin
						fin = 1'b1;
						if (count_x < (CNT_W + 1)'(MAX_ANCHORS)) begin
							mem_we = 1'b1;
							mem_wa = IDX_W'(count_q);
							mem_wd.address = request.anchor_address;
							count_d = count_q + 1'b1;
							fin_rsp.entry_count = 5'(count_q + 1'b1);
						end else begin
							fin_rsp.status = ST_FULL;
						end
					end else if (request.anchor_address == 16'd0 || count_q == '0) begin
						fin = 1'b1;
						fin_rsp.status = ST_MISS;
					end else begin
						mem_re = 1'b1;
						mem_ra = '0;
						state_d = SQ_LOOK;
					end
				end
			end

			// One stored address compared per cycle.
			SQ_LOOK: begin
				if (hit) begin
					case (req_q.command)
						CMD_DELETE: begin
							if (last) begin
								fin = 1'b1;
								count_d = count_q - 1'b1;
								fin_rsp.entry_count = 5'(count_q - 1'b1);
								state_d = SQ_IDLE;
							end else begin
								mem_re = 1'b1;
								mem_ra = IDX_W'(idx_p1);
								state_d = SQ_SHIFT;
							end
						end
						CMD_UPDATE: begin
							div_start = 1'b1;
							state_d = SQ_DIV;
						end
						CMD_QUERY: begin
							fin = 1'b1;
							fin_rsp.filtered_range = rd_q.latest;
							fin_rsp.signal_power = rd_q.power;
							state_d = SQ_IDLE;
						end
						default: begin
							state_d = SQ_IDLE;
						end
					endcase
				end else if (last) begin
					fin = 1'b1;
					fin_rsp.status = ST_MISS;
					state_d = SQ_IDLE;
				end else begin
					mem_re = 1'b1;
					mem_ra = IDX_W'(idx_p1);
					idx_d = IDX_W'(idx_p1);
				end
			end

			// Compaction: the entry just read moves down one place.
			SQ_SHIFT: begin
				mem_we = 1'b1;
				mem_wa = idx_q;
				mem_wd = rd_q;
				idx_d = IDX_W'(idx_p1);
				if (idx_p2 < count_x) begin
					mem_re = 1'b1;
					mem_ra = IDX_W'(idx_p2);
				end else begin
					fin = 1'b1;
					count_d = count_q - 1'b1;
					fin_rsp.entry_count = 5'(count_q - 1'b1);
					state_d = SQ_IDLE;
				end
			end

			// Wait for the filtered range, then write the entry back.
			SQ_DIV: begin
				if (div_done) begin
					mem_we = 1'b1;
					mem_wa = idx_q;
					mem_wd.address = rd_q.address;
					mem_wd.latest = div_quot;
					mem_wd.previous = rd_q.latest;
					mem_wd.power = req_q.measured_power;
					fin = 1'b1;
					fin_rsp.filtered_range = div_quot;
					fin_rsp.signal_power = req_q.measured_power;
					state_d = SQ_IDLE;
				end
			end

			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			idx_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			done_q  <= fin;
		end
	end

	// Captured item and result payload.
	always_ff @(posedge clk) begin
		if (state_q == SQ_IDLE && start) begin
			req_q <= request;
		end
		if (fin) begin
			rsp_q <= fin_rsp;
		end
	end

	// Table memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign busy = (state_q != SQ_IDLE);
	assign done = done_q;
	assign response = rsp_q;

endmodule

`default_nettype wire

[bench/tb_anchor_range_table_core.sv]
// ----------------------------------------------------------------------------
// Anchor range table core testbench
// Drives add, delete, update and query items through the start/busy handshake,
// predicts each result with a behavioural copy of the anchor table, and checks
// every done strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_anchor_range_table_core;
	import art_pkg::*;

	localparam int RANDOM_ITEMS   = 2000;
	localparam int PHASE_LEN      = 100;
	localparam int DRAIN_EVERY    = 250;
	localparam int IDLE_PERCENT   = 21;
	localparam int QUIET_FIRST    = 900;
	localparam int QUIET_LAST     = 1300;
	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 2000;

	// One planned item and whether the sender waits for all results before it.
	typedef struct {
		req_t item;
		bit   drain_first;
	} planned_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t response;

	planned_item_t planned_items[$];
	rsp_t          expected_responses[$];
	logic [15:0]   shadow_addresses[$];

	// Behavioural copy of the anchor table.
	logic [15:0]        tbl_address[ART_MAX_ANCHORS];
	logic [15:0]        tbl_latest[ART_MAX_ANCHORS];
	logic [15:0]        tbl_previous[ART_MAX_ANCHORS];
	logic signed [15:0] tbl_power[ART_MAX_ANCHORS];
	int                 tbl_count = 0;

	int items_planned = 0;
	int items_issued = 0;
	int results_seen = 0;
	int failures = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;
	int cmd_count[4] = '{0, 0, 0, 0};
	int status_count[3] = '{0, 0, 0};

	anchor_range_table_core #(
		.MAX_ANCHORS(ART_MAX_ANCHORS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.response(response)
	);

	// Free-running clock.
	always #5 clk = ~clk;

	// Applies one item to the table copy and returns the result it should give.
	function automatic rsp_t anchor_table_step(req_t cmd_item);
		rsp_t        r;
		int          idx;
		logic [17:0] sum;
		r = '0;
		r.status = ST_DONE;
		idx = -1;
		if (cmd_item.command == CMD_ADD) begin
			if (tbl_count < ART_MAX_ANCHORS) begin
				tbl_address[tbl_count] = cmd_item.anchor_address;
				tbl_latest[tbl_count] = '0;
				tbl_previous[tbl_count] = '0;
				tbl_power[tbl_count] = '0;
				tbl_count++;
			end else begin
				r.status = ST_FULL;
			end
		end else begin
			// Address zero never matches; otherwise the oldest match wins.
			if (cmd_item.anchor_address != 16'd0) begin
				for (int i = 0; i < tbl_count; i++) begin
					if (idx < 0 && tbl_address[i] == cmd_item.anchor_address)
						idx = i;
				end
			end
			if (idx < 0) begin
				r.status = ST_MISS;
			end else if (cmd_item.command == CMD_DELETE) begin
				for (int i = idx; i + 1 < tbl_count; i++) begin
					tbl_address[i] = tbl_address[i + 1];
					tbl_latest[i] = tbl_latest[i + 1];
					tbl_previous[i] = tbl_previous[i + 1];
					tbl_power[i] = tbl_power[i + 1];
				end
				tbl_count--;
			end else begin
				if (cmd_item.command == CMD_UPDATE) begin
					sum = 18'(cmd_item.measured_range) + 18'(tbl_latest[idx])
						+ 18'(tbl_previous[idx]);
					tbl_previous[idx] = tbl_latest[idx];
					tbl_latest[idx] = 16'(sum / 18'd3);
					tbl_power[idx] = cmd_item.measured_power;
				end
				r.filtered_range = tbl_latest[idx];
				r.signal_power = tbl_power[idx];
			end
		end
		r.entry_count = 5'(tbl_count);
		cmd_count[cmd_item.command]++;
		status_count[r.status]++;
		return r;
	endfunction

	// Queues one item and tracks which addresses the table should then hold.
	task automatic plan_item(cmd_t c, logic [15:0] addr, logic [15:0] rng,
			logic signed [15:0] pwr, bit drain);
		planned_item_t p;
		int            hit;
		p.item.command = c;
		p.item.anchor_address = addr;
		p.item.measured_range = rng;
		p.item.measured_power = pwr;
		p.drain_first = drain;
		planned_items.push_back(p);
		items_planned++;
		hit = -1;
		if (c == CMD_ADD && shadow_addresses.size() < ART_MAX_ANCHORS) begin
			shadow_addresses.push_back(addr);
		end else if (c == CMD_DELETE && addr != 16'd0) begin
			foreach (shadow_addresses[i])
				if (hit < 0 && shadow_addresses[i] == addr)
					hit = i;
			if (hit >= 0)
				shadow_addresses.delete(hit);
		end
	endtask

	// Reports one result field that differs from its prediction.
	task automatic check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			$display("%t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// Sender: records accepted items, holds start while busy and idles at random.
	always @(posedge clk or negedge arst_n) begin : driver
		bit            ready;
		bit            quiet;
		planned_item_t pending;
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				expected_responses.push_back(anchor_table_step(request));
				items_issued++;
			end
			if (!(start && busy)) begin
				ready = planned_items.size() > 0;
				if (ready && planned_items[0].drain_first && results_seen != items_issued)
					ready = 1'b0;
				quiet = items_issued >= QUIET_FIRST && items_issued < QUIET_LAST;
				if (ready && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
					pending = planned_items.pop_front();
					start <= 1'b1;
					request <= pending.item;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver: every done strobe is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			results_seen <= results_seen + 1;
			if (expected_responses.size() == 0) begin
				$display("%t: result with nothing expected, got status %0d range %0d",
					$time, response.status, response.filtered_range);
				failures++;
			end else begin
				want = expected_responses.pop_front();
				check_field("status", want.status, response.status);
				check_field("filtered_range", want.filtered_range,
					response.filtered_range);
				check_field("signal_power", want.signal_power, response.signal_power);
				check_field("entry_count", want.entry_count, response.entry_count);
			end
		end
	end

	// Watchdog: counts cycles in which neither an item nor a result moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT)
			timed_out <= 1'b1;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Stimulus plan, reset and end of run.
	initial begin
		cmd_t        c;
		logic [15:0] addr;
		logic [15:0] rng;
		logic [15:0] pwr;
		int          mode;
		int          pick;
		int          leftover;

		// Directed part: empty table, zero address, duplicates, extreme values.
		plan_item(CMD_QUERY, 16'h0005, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_UPDATE, 16'h0005, 16'd100, 16'sd5, 1'b0);
		plan_item(CMD_DELETE, 16'h0005, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_ADD, 16'h0000, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_QUERY, 16'h0000, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_ADD, 16'hFFFF, 16'hFFFF, -16'sd1, 1'b0);
		plan_item(CMD_ADD, 16'h1234, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_ADD, 16'h1234, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_UPDATE, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b0);
		plan_item(CMD_UPDATE, 16'hFFFF, 16'hFFFF, 16'sh8000, 1'b0);
		plan_item(CMD_UPDATE, 16'hFFFF, 16'hFFFF, 16'sd0, 1'b0);
		plan_item(CMD_QUERY, 16'hFFFF, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_UPDATE, 16'h1234, 16'd0, -16'sd1, 1'b0);
		plan_item(CMD_UPDATE, 16'h1234, 16'd1, 16'sd1, 1'b0);
		plan_item(CMD_DELETE, 16'h1234, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_QUERY, 16'h1234, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_DELETE, 16'h0000, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_ADD, 16'h0001, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_DELETE, 16'hFFFF, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_QUERY, 16'h0001, 16'd0, 16'sd0, 1'b0);
		plan_item(CMD_UPDATE, 16'h8000, 16'd7, 16'sd7, 1'b0);

		// Random part in phases that fill, drain or churn the table.
		mode = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0)
				mode = (n == 0) ? 0 : $urandom_range(2);
			pick = $urandom_range(99);
			case (mode)
				0: c = pick < 50 ? CMD_ADD : pick < 75 ? CMD_UPDATE :
					pick < 90 ? CMD_QUERY : CMD_DELETE;
				1: c = pick < 10 ? CMD_ADD : pick < 35 ? CMD_UPDATE :
					pick < 55 ? CMD_QUERY : CMD_DELETE;
				default: c = cmd_t'(pick % 4);
			endcase
			pick = $urandom_range(99);
			if (c == CMD_ADD) begin
				// A small pool makes duplicates; zero adds would clog the table.
				addr = pick < 60 ? 16'($urandom_range(24, 1)) : 16'($urandom_range(65535, 1));
			end else if (pick < 75 && shadow_addresses.size() > 0) begin
				addr = shadow_addresses[$urandom_range(shadow_addresses.size() - 1)];
			end else if (pick < 85) begin
				addr = 16'd0;
			end else begin
				addr = 16'($urandom);
			end
			pick = $urandom_range(99);
			rng = pick < 10 ? 16'hFFFF : pick < 20 ? 16'd0 : 16'($urandom);
			pick = $urandom_range(99);
			pwr = pick < 5 ? 16'h7FFF : pick < 10 ? 16'h8000 : 16'($urandom);
			plan_item(c, addr, rng, pwr, n % DRAIN_EVERY == 0);
		end

		// Reset once, then let the driver and monitor run.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait ((items_issued == items_planned && results_seen == items_issued) || timed_out);
		if (!timed_out)
			repeat (SETTLE_CYCLES) @(posedge clk);
		if (timed_out)
			$display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
		leftover = expected_responses.size();
		if (leftover > 0) begin
			$display("%t: %0d expected results never arrived", $time, leftover);
			failures += leftover;
		end

		$display("Covered %0d items (%0d add, %0d delete, %0d update, %0d query), %0d results",
			items_issued, cmd_count[CMD_ADD], cmd_count[CMD_DELETE],
			cmd_count[CMD_UPDATE], cmd_count[CMD_QUERY], results_seen);
		$display("Lookups missed: %0d, adds refused on a full table: %0d, failures: %0d",
			status_count[ST_MISS], status_count[ST_FULL], failures);
		if (!timed_out && failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[anchor_range_table_core.f]
sv/art_pkg.sv
sv/art_div3.sv
sv/anchor_range_table_core.sv
bench/tb_anchor_range_table_core.sv
